@@ design/line_substring_filter_core_defines.svh @@
// line_substring_filter_core_defines.svh: assertion macros for the line filter checker
// no dependencies; included by the checker file
`ifndef LINE_SUBSTRING_FILTER_CORE_DEFINES_SVH
`define LINE_SUBSTRING_FILTER_CORE_DEFINES_SVH

// clocked property with reset disable
`define LSF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen
`define LSF_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/lsf_pkg.sv @@
// lsf_pkg: word types, register indexes and constants of the line substring filter
// no dependencies; used by the core and its checker
package lsf_pkg;

  // newline byte that ends a line
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // configuration register index width
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_IGNORE_CASE    = 3'd3,
    CFG_INVERT_SELECT  = 3'd4
  } cfg_index_t;

  // one text word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } text_word_t;

  // one result word, one per finished line
  typedef struct packed {
    logic [31:0] line_number;
    logic        line_hit;
    logic        line_selected;
    logic        file_matched;
  } result_word_t;

endpackage

@@ design/line_substring_filter_core.sv @@
// line_substring_filter_core: per-line substring match over a byte stream
// depends on lsf_pkg for word types, register indexes and the newline constant
//
// Takes one text byte per cycle and reports, at every line end (newline byte or the
// byte flagged end_of_input), whether the line contained the configured pattern of up
// to PATTERN_MAX bytes. The window of recent bytes is compared against the pattern in
// parallel in the same cycle the byte is accepted, and the result is captured in the
// output register. Throughput is one byte per clock; the input stalls only
// while the output register holds a result that has not been taken. Configuration
// writes are accepted every cycle and should only be made while no line is in flight.
module line_substring_filter_core #(
  parameter int PATTERN_MAX     = 16,
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_ready,
  input  lsf_pkg::text_word_t             text,
  output logic                            result_valid,
  input  logic                            result_ready,
  output lsf_pkg::result_word_t           result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // ascii upper to lower folding when enabled
  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    if (en && (c inside {[8'h41:8'h5A]})) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // configuration registers
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic        ignore_case;
  logic        invert_select;

  // line and file state
  logic [7:0]                 window [PATTERN_MAX];
  logic [CNT_W-1:0]           bytes_in_line;
  logic                       hit_in_line;
  logic [LINE_COUNT_BITS-1:0] line_count;
  logic                       any_selected;

  logic [7:0]                 window_next [PATTERN_MAX];
  logic [7:0]                 pat_bytes [PATTERN_MAX];
  logic [CNT_W-1:0]           bytes_next;
  logic [CNT_W-1:0]           len_eff;
  logic                       match_ok;
  logic                       line_match;
  logic                       hit_next;
  logic                       line_end;
  logic                       text_acc;
  logic [LINE_COUNT_BITS-1:0] count_next;
  logic [63:0]                count_ext;
  logic                       sel;
  logic                       any_next;
  lsf_pkg::result_word_t      result_next;

  assign cfg_ready  = 1'b1;
  assign text_ready = !result_valid || result_ready;
  assign text_acc   = text_valid && text_ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      ignore_case    <= 1'b0;
      invert_select  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsf_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        lsf_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        lsf_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        lsf_pkg::CFG_IGNORE_CASE:    ignore_case    <= cfg_data[0];
        lsf_pkg::CFG_INVERT_SELECT:  invert_select  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shifted window and unpacked pattern bytes
  always_comb begin
    window_next[0] = text.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k < 8) begin
        pat_bytes[k] = pattern_low[8*(k & 7) +: 8];
      end else begin
        pat_bytes[k] = pattern_high[8*(k & 7) +: 8];
      end
    end
  end

  // saturated byte count and effective pattern length
  assign bytes_next = (bytes_in_line < CNT_W'(PATTERN_MAX)) ?
                      bytes_in_line + CNT_W'(1) : bytes_in_line;
  assign len_eff    = (pattern_length > 5'(PATTERN_MAX)) ?
                      CNT_W'(PATTERN_MAX) : CNT_W'(pattern_length);

  // pattern byte k against window byte len-1-k
  always_comb begin
    logic [IDX_W-1:0] pos;
    match_ok = 1'b1;
    pos      = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k < int'(len_eff)) begin
        pos = IDX_W'(int'(len_eff) - 1 - k);
        if (fold(window_next[pos], ignore_case) != fold(pat_bytes[k], ignore_case)) begin
          match_ok = 1'b0;
        end
      end
    end
    line_match = (len_eff == '0) || ((bytes_next >= len_eff) && match_ok);
  end

  assign hit_next = hit_in_line || line_match;
  assign line_end = (text.data_byte == lsf_pkg::NEWLINE_BYTE) || text.end_of_input;

  // line count, selection and file flag for the finished line
  assign count_next = (line_count != '1) ? line_count + LINE_COUNT_BITS'(1) : line_count;
  assign count_ext  = 64'(count_next);
  assign sel        = hit_next ^ invert_select;
  assign any_next   = any_selected || sel;

  always_comb begin
    result_next.line_number   = (count_ext > 64'h0000_0000_FFFF_FFFF) ?
                                32'hFFFF_FFFF : count_ext[31:0];
    result_next.line_hit      = hit_next;
    result_next.line_selected = sel;
    result_next.file_matched  = any_next;
  end

  // line and file state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window[j] <= '0;
      end
      bytes_in_line <= '0;
      hit_in_line   <= 1'b0;
      line_count    <= '0;
      any_selected  <= 1'b0;
    end else if (text_acc) begin
      if (line_end) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
          window[j] <= '0;
        end
        bytes_in_line <= '0;
        hit_in_line   <= 1'b0;
        if (text.end_of_input) begin
          line_count   <= '0;
          any_selected <= 1'b0;
        end else begin
          line_count   <= count_next;
          any_selected <= any_next;
        end
      end else begin
        window        <= window_next;
        bytes_in_line <= bytes_next;
        hit_in_line   <= hit_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (text_acc && line_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc && line_end) begin
      result <= result_next;
    end
  end

endmodule

@@ design/lsf_checker.sv @@
// lsf_checker: port-level assertions for line_substring_filter_core, bound into every instance of it
// depends on lsf_pkg and line_substring_filter_core_defines.svh
`include "line_substring_filter_core_defines.svh"

module lsf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            text_valid,
  input logic                            text_ready,
  input lsf_pkg::text_word_t             text,
  input logic                            result_valid,
  input logic                            result_ready,
  input lsf_pkg::result_word_t           result,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [63:0]                     cfg_data
);

  // a stalled result word holds
  `LSF_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")

  // a new result only follows an accepted line-ending byte
  `LSF_ASSERT(a_result_cause, clk, rst, $rose(result_valid) |-> $past(text_valid && text_ready && (text.data_byte == lsf_pkg::NEWLINE_BYTE || text.end_of_input)), "result without a line end")

  // a selected line marks its file as matched
  `LSF_ASSERT(a_sel_file, clk, rst, result_valid && result.line_selected |-> result.file_matched, "selected line without file match")

  // line numbers are one based
  `LSF_ASSERT_NEVER(a_line_zero, clk, rst, result_valid && result.line_number == 32'd0, "line number zero")

  // input is never stalled while the output register is free
  `LSF_ASSERT(a_no_idle_stall, clk, rst, !result_valid |-> text_ready, "input stalled with empty output")

endmodule

bind line_substring_filter_core lsf_checker u_lsf_checker (.*);
